// File: rtl/core/calu_pkg.sv
// ----------------------------------------------------------------------------
// calu_pkg
// Types and operation codes shared by the ALU with flags.
// ----------------------------------------------------------------------------
package calu_pkg;

  typedef enum logic [5:0] {
    CMD_INC8   = 6'd0,
    CMD_DEC8   = 6'd1,
    CMD_INC16  = 6'd2,
    CMD_DEC16  = 6'd3,
    CMD_ADD8   = 6'd4,
    CMD_ADC8   = 6'd5,
    CMD_SUB8   = 6'd6,
    CMD_SBC8   = 6'd7,
    CMD_CP8    = 6'd8,
    CMD_AND8   = 6'd9,
    CMD_OR8    = 6'd10,
    CMD_XOR8   = 6'd11,
    CMD_AND16  = 6'd12,
    CMD_OR16   = 6'd13,
    CMD_ADD16  = 6'd14,
    CMD_ADC16  = 6'd15,
    CMD_SUB16  = 6'd16,
    CMD_SBC16  = 6'd17,
    CMD_CPL    = 6'd18,
    CMD_BOOL   = 6'd19,
    CMD_RLCA   = 6'd20,
    CMD_RLA    = 6'd21,
    CMD_RRCA   = 6'd22,
    CMD_RRA    = 6'd23,
    CMD_RLC    = 6'd24,
    CMD_RL     = 6'd25,
    CMD_RRC    = 6'd26,
    CMD_RR     = 6'd27,
    CMD_RL16   = 6'd28,
    CMD_RR16   = 6'd29,
    CMD_SLA    = 6'd30,
    CMD_SRA    = 6'd31,
    CMD_SRL    = 6'd32,
    CMD_BIT    = 6'd33,
    CMD_SET    = 6'd34,
    CMD_RES    = 6'd35,
    CMD_ADDSP  = 6'd36,
    CMD_MUL    = 6'd37
  } calu_cmd_t;

  typedef struct packed {
    calu_cmd_t   cmd;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic        sign_in;
    logic        zero_in;
    logic        lv_in;
    logic        carry_in;
  } calu_in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        sign_out;
    logic        zero_out;
    logic        lv_out;
    logic        carry_out;
  } calu_out_t;

endpackage

// File: rtl/core/calu_exec.sv
// ----------------------------------------------------------------------------
// calu_exec
// Combinational execute stage: computes the result and flags of one item.
// ----------------------------------------------------------------------------
module calu_exec (
  input  calu_pkg::calu_in_t  in_i,
  output calu_pkg::calu_out_t out_o
);

  logic [15:0] a;
  logic [15:0] b;
  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        ci;
  logic [8:0]  add8;
  logic [8:0]  sub8;
  logic [16:0] add16;
  logic [16:0] sub16;
  logic [16:0] sp_sum;
  logic [31:0] prod;
  logic [7:0]  bmask;

  assign a     = in_i.operand_a;
  assign b     = in_i.operand_b;
  assign a8    = a[7:0];
  assign b8    = b[7:0];
  assign bmask = 8'd1 << in_i.bit_index;
  assign prod  = 32'($signed(a) * $signed(b));

  always_comb begin
    ci = 1'b0;
    if ((in_i.cmd == calu_pkg::CMD_ADC8) || (in_i.cmd == calu_pkg::CMD_SBC8) ||
        (in_i.cmd == calu_pkg::CMD_ADC16) || (in_i.cmd == calu_pkg::CMD_SBC16)) begin
      ci = in_i.carry_in;
    end
  end

  assign add8   = {1'b0, a8} + {1'b0, b8} + {8'd0, ci};
  assign sub8   = {1'b0, a8} - {1'b0, b8} - {8'd0, ci};
  assign add16  = {1'b0, a} + {1'b0, b} + {16'd0, ci};
  assign sub16  = {1'b0, a} - {1'b0, b} - {16'd0, ci};
  assign sp_sum = {1'b0, a} + {{9{b8[7]}}, b8};

  always_comb begin
    logic [7:0]  r8;
    logic [15:0] r16;
    r8  = 8'd0;
    r16 = 16'd0;
    out_o.result    = 32'd0;
    out_o.sign_out  = in_i.sign_in;
    out_o.zero_out  = in_i.zero_in;
    out_o.lv_out    = in_i.lv_in;
    out_o.carry_out = in_i.carry_in;
    case (in_i.cmd)
      calu_pkg::CMD_INC8, calu_pkg::CMD_DEC8: begin
        r8 = (in_i.cmd == calu_pkg::CMD_INC8) ? b8 + 8'd1 : b8 - 8'd1;
        out_o.result   = {24'd0, r8};
        out_o.lv_out   = (in_i.cmd == calu_pkg::CMD_INC8) ? (r8 == 8'h80) : (r8 == 8'h7f);
        out_o.sign_out = r8[7];
        out_o.zero_out = (r8 == 8'd0);
      end
      calu_pkg::CMD_INC16: out_o.result = {16'd0, b + 16'd1};
      calu_pkg::CMD_DEC16: out_o.result = {16'd0, b - 16'd1};
      calu_pkg::CMD_ADD8, calu_pkg::CMD_ADC8: begin
        r8 = add8[7:0];
        out_o.result    = {24'd0, r8};
        out_o.carry_out = add8[8];
        out_o.lv_out    = ~(a8[7] ^ b8[7]) & (a8[7] ^ r8[7]);
        out_o.sign_out  = r8[7];
        out_o.zero_out  = (r8 == 8'd0);
      end
      calu_pkg::CMD_SUB8, calu_pkg::CMD_SBC8: begin
        r8 = sub8[7:0];
        out_o.result    = {24'd0, r8};
        out_o.carry_out = sub8[8];
        out_o.lv_out    = (a8[7] ^ b8[7]) & (a8[7] ^ r8[7]);
        out_o.sign_out  = r8[7];
        out_o.zero_out  = (r8 == 8'd0);
      end
      calu_pkg::CMD_CP8: begin
        r8 = sub8[7:0];
        out_o.lv_out    = (a8[7] ^ b8[7]) & (a8[7] ^ r8[7]);
        out_o.sign_out  = sub8[8];
        out_o.carry_out = sub8[8];
        out_o.zero_out  = (a8 == b8);
      end
      calu_pkg::CMD_AND8, calu_pkg::CMD_OR8, calu_pkg::CMD_XOR8: begin
        case (in_i.cmd)
          calu_pkg::CMD_AND8: r8 = a8 & b8;
          calu_pkg::CMD_OR8:  r8 = a8 | b8;
          default:            r8 = a8 ^ b8;
        endcase
        out_o.result    = {24'd0, r8};
        out_o.carry_out = 1'b0;
        out_o.lv_out    = (r8[7:4] != 4'd0);
        out_o.sign_out  = r8[7];
        out_o.zero_out  = (r8 == 8'd0);
      end
      calu_pkg::CMD_AND16, calu_pkg::CMD_OR16: begin
        r16 = (in_i.cmd == calu_pkg::CMD_AND16) ? (a & b) : (a | b);
        out_o.result    = {16'd0, r16};
        out_o.carry_out = 1'b0;
        out_o.lv_out    = (r16[15:12] != 4'd0);
        out_o.sign_out  = r16[15];
        out_o.zero_out  = (r16 == 16'd0);
      end
      calu_pkg::CMD_ADD16: begin
        out_o.result    = {16'd0, add16[15:0]};
        out_o.carry_out = add16[16];
      end
      calu_pkg::CMD_ADC16: begin
        r16 = add16[15:0];
        out_o.result    = {16'd0, r16};
        out_o.carry_out = add16[16];
        out_o.lv_out    = ~(a[15] ^ b[15]) & (a[15] ^ r16[15]);
        out_o.sign_out  = r16[15];
        out_o.zero_out  = (r16 == 16'd0);
      end
      calu_pkg::CMD_SUB16, calu_pkg::CMD_SBC16: begin
        r16 = sub16[15:0];
        out_o.result    = {16'd0, r16};
        out_o.carry_out = sub16[16];
        out_o.lv_out    = (a[15] ^ b[15]) & (a[15] ^ r16[15]);
        out_o.sign_out  = r16[15];
        out_o.zero_out  = (r16 == 16'd0);
      end
      calu_pkg::CMD_CPL: out_o.result = {24'd0, ~a8};
      calu_pkg::CMD_BOOL: begin
        out_o.result    = {31'd0, (a != 16'd0)};
        out_o.zero_out  = (a == 16'd0);
        out_o.sign_out  = 1'b0;
        out_o.lv_out    = 1'b0;
        out_o.carry_out = 1'b0;
      end
      calu_pkg::CMD_RLCA: begin
        out_o.result    = {24'd0, b8[6:0], b8[7]};
        out_o.carry_out = b8[7];
      end
      calu_pkg::CMD_RLA: begin
        out_o.result    = {24'd0, b8[6:0], in_i.carry_in};
        out_o.carry_out = b8[7];
      end
      calu_pkg::CMD_RRCA: begin
        out_o.result    = {24'd0, b8[0], b8[7:1]};
        out_o.carry_out = b8[0];
      end
      calu_pkg::CMD_RRA: begin
        out_o.result    = {24'd0, in_i.carry_in, b8[7:1]};
        out_o.carry_out = b8[0];
      end
      calu_pkg::CMD_RLC, calu_pkg::CMD_RL, calu_pkg::CMD_RRC, calu_pkg::CMD_RR,
      calu_pkg::CMD_SLA, calu_pkg::CMD_SRA, calu_pkg::CMD_SRL: begin
        case (in_i.cmd)
          calu_pkg::CMD_RLC: r8 = {b8[6:0], b8[7]};
          calu_pkg::CMD_RL:  r8 = {b8[6:0], in_i.carry_in};
          calu_pkg::CMD_RRC: r8 = {b8[0], b8[7:1]};
          calu_pkg::CMD_RR:  r8 = {in_i.carry_in, b8[7:1]};
          calu_pkg::CMD_SLA: r8 = {b8[6:0], 1'b0};
          calu_pkg::CMD_SRA: r8 = {b8[7], b8[7:1]};
          default:           r8 = {1'b0, b8[7:1]};
        endcase
        out_o.result    = {24'd0, r8};
        out_o.carry_out = ((in_i.cmd == calu_pkg::CMD_RLC) || (in_i.cmd == calu_pkg::CMD_RL) ||
                           (in_i.cmd == calu_pkg::CMD_SLA)) ? b8[7] : b8[0];
        out_o.lv_out    = (r8[7:4] != 4'd0);
        out_o.sign_out  = r8[7];
        out_o.zero_out  = (r8 == 8'd0);
      end
      calu_pkg::CMD_RL16, calu_pkg::CMD_RR16: begin
        r16 = (in_i.cmd == calu_pkg::CMD_RL16) ? {b[14:0], in_i.carry_in}
                                               : {in_i.carry_in, b[15:1]};
        out_o.result    = {16'd0, r16};
        out_o.carry_out = (in_i.cmd == calu_pkg::CMD_RL16) ? b[15] : b[0];
        out_o.lv_out    = (r16[15:12] != 4'd0);
        out_o.sign_out  = r16[15];
        out_o.zero_out  = (r16 == 16'd0);
      end
      calu_pkg::CMD_BIT: out_o.zero_out = ((b8 & bmask) == 8'd0);
      calu_pkg::CMD_SET: out_o.result = {24'd0, b8 | bmask};
      calu_pkg::CMD_RES: out_o.result = {24'd0, b8 & ~bmask};
      calu_pkg::CMD_ADDSP: begin
        out_o.result    = {16'd0, sp_sum[15:0]};
        out_o.carry_out = sp_sum[16];
      end
      calu_pkg::CMD_MUL: out_o.result = prod;
      default: out_o.result = 32'd0;
    endcase
  end

endmodule

// File: rtl/core/cpu_alu_8_16_with_flags_top.sv
// ----------------------------------------------------------------------------
// cpu_alu_8_16_with_flags_top
// ALU of an 8/16-bit processor with sign, zero, logical/overflow and carry.
// ----------------------------------------------------------------------------
// An item is taken whenever start is high; busy is never raised, so one item
// can be issued in every cycle. Each item is captured in an input register,
// executed by one pass of combinational logic and its result registered; out_valid
// pulses for one cycle per item, together with the registered result on out_item.
// The receiver cannot stall and must take each result in the cycle it appears.
module cpu_alu_8_16_with_flags_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  calu_pkg::calu_in_t  in_item,
  output logic                out_valid,
  output calu_pkg::calu_out_t out_item
);

  logic                valid_r;
  logic                valid_nxt;
  calu_pkg::calu_in_t  item_r;
  logic                out_valid_r;
  calu_pkg::calu_out_t res_nxt;
  calu_pkg::calu_out_t res_r;

  assign busy      = 1'b0;
  assign valid_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_nxt) begin
      item_r <= in_item;
    end
    if (valid_r) begin
      res_r <= res_nxt;
    end
  end

  calu_exec u_exec (
    .in_i  (item_r),
    .out_o (res_nxt)
  );

  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted item produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |=> !out_valid)
    else $error("result strobe without an item in execution");

  a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !valid_r)
    else $error("execute stage valid without an accepted item");

endmodule
